// ===== design/pwe_pkg.sv =====
// Shared types and constants of the pooling window engine
package pwe_pkg;
  localparam int MAX_DIM      = 64;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_WINDOW   = 8;
  localparam int VALUE_WIDTH  = 16;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int ADDR_W  = 2 * DIM_W + CH_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_CHANNELS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W   = 7;
  localparam int ACC_W   = VALUE_WIDTH + CNT_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_PADDING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_ROWS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COLS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd7;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_SIGN  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;
endpackage

// ===== design/pooling_window_engine_unit.sv =====
// Top level of the pooling window engine: frame store, sequencer and shared ALU
// Usage: the input channel (in_valid/in_stall) carries write and query requests.
// A write request stores one Q8.8 frame entry and gives no result; writes are
// taken back to back, one a cycle. A query request names an output row, column
// and channel and gives one result on the output channel (out_valid/out_stall).
// A query walks its window one cell a cycle through the single read port of the
// frame store, with one shared adder/comparator. A max query then registers its
// result; a mean query first runs a restoring divider (one quotient bit a cycle
// over ACC_W bits) and a sign step. An out-of-range query skips the walk.
// The block takes no new request while a query is in work or its result waits.
// The result register holds while out_stall is high.
// Reset (rst, synchronous) restores the configuration defaults and clears the
// control state. The frame store is not cleared: read an entry only once written.
// The user must write configuration (cfg_write, cfg_index, cfg_data) only while
// idle; the block itself does not enforce it.
module pooling_window_engine_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [pwe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic operation,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic [3:0] channel,
  input  logic signed [15:0] pixel_value,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] pooled_value,
  output logic [6:0] valid_cells,
  output logic out_of_range
);
  import pwe_pkg::*;

  // configuration registers
  logic pool_mode, use_padding;
  logic [3:0] window_size, stride;
  logic signed [15:0] pad_value;
  logic [6:0] input_rows, input_cols;
  logic [4:0] channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode <= 1'b0; window_size <= 4'd2; stride <= 4'd2; use_padding <= 1'b0;
      pad_value <= '0; input_rows <= 7'd64; input_cols <= 7'd64; channels <= 5'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POOL_MODE:   pool_mode <= cfg_data[0];
        REG_WINDOW_SIZE: window_size <= cfg_data[3:0];
        REG_STRIDE:      stride <= cfg_data[3:0];
        REG_USE_PADDING: use_padding <= cfg_data[0];
        REG_PAD_VALUE:   pad_value <= cfg_data;
        REG_INPUT_ROWS:  input_rows <= cfg_data[6:0];
        REG_INPUT_COLS:  input_cols <= cfg_data[6:0];
        REG_CHANNELS:    channels <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // frame store, one write port and one registered read port
  logic [VALUE_WIDTH-1:0] frame_store [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) frame_store[{row, col, channel}] <= pixel_value;
    rd_data <= frame_store[rd_addr];
  end

  state_t state;
  logic in_acc;
  assign in_stall = (state != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign wr_en = in_acc && (operation == OP_WRITE);

  // query registers
  logic [5:0] q_row, q_col;
  logic [3:0] q_ch;
  logic [3:0] w;
  logic [5:0] rlo, rhi, clo, chi;
  logic [5:0] r, c;
  logic last_rd, pend;
  logic signed [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cells;
  logic [ACC_W-1:0] mag, quo, rem;
  logic neg;
  logic [4:0] dcnt;

  // per-dimension window bounds (combinational, narrow)
  logic [3:0] w_eff, s_eff;
  logic [6:0] rows_e, cols_e;
  logic [4:0] nch_e;
  logic [2:0] left;
  logic [3:0] right;
  logic [9:0] prow, pcol;
  logic row_ok, col_ok;
  logic [9:0] rc, cc;
  logic [5:0] rlo_next, rhi_next, clo_next, chi_next;

  always_comb begin
    w_eff = (window_size == 0) ? 4'd1 : (window_size > 4'd8 ? 4'd8 : window_size);
    s_eff = (stride == 0) ? 4'd1 : stride;
    rows_e = (input_rows > 7'd64) ? 7'd64 : input_rows;
    cols_e = (input_cols > 7'd64) ? 7'd64 : input_cols;
    nch_e = (channels > 5'd16) ? 5'd16 : channels;
    left = 3'((w_eff - 4'd1) >> 1);
    right = w_eff >> 1;
    // extent check: out*stride must not pass the last start position
    prow = 10'(q_row) * 10'(s_eff);
    pcol = 10'(q_col) * 10'(s_eff);
    if (use_padding) begin
      row_ok = (rows_e != 0) && (prow <= 10'(rows_e) - 10'd1);
      col_ok = (cols_e != 0) && (pcol <= 10'(cols_e) - 10'd1);
    end else begin
      row_ok = (rows_e >= 7'(w_eff)) && (prow <= 10'(rows_e) - 10'(w_eff));
      col_ok = (cols_e >= 7'(w_eff)) && (pcol <= 10'(cols_e) - 10'(w_eff));
    end
    rc = prow + (use_padding ? 10'd0 : 10'(left));
    cc = pcol + (use_padding ? 10'd0 : 10'(left));
    // covered range, clipped to the frame
    rlo_next = (rc < 10'(left)) ? 6'd0 : 6'(rc - 10'(left));
    rhi_next = (rc + 10'(right) > 10'(rows_e) - 10'd1) ?
               6'(rows_e - 7'd1) : 6'(rc + 10'(right));
    clo_next = (cc < 10'(left)) ? 6'd0 : 6'(cc - 10'(left));
    chi_next = (cc + 10'(right) > 10'(cols_e) - 10'd1) ?
               6'(cols_e - 7'd1) : 6'(cc + 10'(right));
  end

  logic oor;
  assign oor = (5'(q_ch) >= nch_e) || !row_ok || !col_ok;

  always_comb begin
    rd_addr = {r, c, q_ch};
  end

  logic signed [ACC_W-1:0] rd_ext;
  assign rd_ext = ACC_W'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && operation == OP_QUERY) begin
            q_row <= row; q_col <= col; q_ch <= channel;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          w <= w_eff;
          if (oor) begin
            pooled_value <= '0; valid_cells <= '0; out_of_range <= 1'b1;
            out_valid <= 1'b1;
            state <= ST_OUT;
          end else begin
            rlo <= rlo_next; rhi <= rhi_next;
            clo <= clo_next; chi <= chi_next;
            r <= rlo_next; c <= clo_next;
            cells <= CNT_W'((7'(rhi_next) - 7'(rlo_next) + 7'd1) *
                            (7'(chi_next) - 7'(clo_next) + 7'd1));
            out_of_range <= 1'b0;
            pend <= 1'b0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // initial accumulator, then fetch cells one per cycle
          if (pool_mode) acc <= '0;
          else if (cells != CNT_W'(w * w)) acc <= ACC_W'(pad_value);
          else acc <= -(ACC_W'(1) <<< (VALUE_WIDTH - 1));
          last_rd <= (r == rhi) && (c == chi);
          pend <= 1'b1;
          if (c == chi) begin c <= clo; r <= r + 6'd1; end
          else c <= c + 6'd1;
          state <= ST_ACC;
        end
        ST_ACC: begin
          // shared adder / comparator on the cell read last cycle
          if (pend) begin
            if (pool_mode) acc <= acc + rd_ext;
            else if (rd_ext > acc) acc <= rd_ext;
          end
          if (pend && last_rd) begin
            pend <= 1'b0;
            if (pool_mode) state <= ST_DIV;
            else begin
              pooled_value <= (rd_ext > acc) ? rd_ext[15:0] : acc[15:0];
              valid_cells <= cells; out_valid <= 1'b1; state <= ST_OUT;
            end
          end else begin
            last_rd <= (r == rhi) && (c == chi);
            if (c == chi) begin c <= clo; r <= r + 6'd1; end
            else c <= c + 6'd1;
          end
          if (pool_mode && pend && last_rd) begin
            neg <= (acc + rd_ext) < 0;
            mag <= ((acc + rd_ext) < 0) ? ACC_W'(-(acc + rd_ext)) : ACC_W'(acc + rd_ext);
            quo <= '0; rem <= '0; dcnt <= 5'(ACC_W);
          end
        end
        ST_DIV: begin
          // restoring divider, one quotient bit a cycle
          if (dcnt == 0) state <= ST_SIGN;
          else begin
            dcnt <= dcnt - 5'd1;
            mag <= mag << 1;
            if ({rem[ACC_W-2:0], mag[ACC_W-1]} >= ACC_W'(cells)) begin
              rem <= {rem[ACC_W-2:0], mag[ACC_W-1]} - ACC_W'(cells);
              quo <= {quo[ACC_W-2:0], 1'b1};
            end else begin
              rem <= {rem[ACC_W-2:0], mag[ACC_W-1]};
              quo <= {quo[ACC_W-2:0], 1'b0};
            end
          end
        end
        ST_SIGN: begin
          pooled_value <= neg ? 16'(-quo) : quo[15:0];
          valid_cells <= cells; out_valid <= 1'b1; state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin out_valid <= 1'b0; state <= ST_IDLE; end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== design/pwe_checker.sv =====
// Port-level checker for the pooling window engine and its bind
module pwe_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [15:0] pooled_value,
  input logic [6:0] valid_cells,
  input logic out_of_range
);
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> pooled_value == 0 && valid_cells == 0) else $error("oor");
  a_cells: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> valid_cells != 0 && valid_cells <= 7'd64) else $error("cells");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pooled_value)) else $error("hold");
endmodule

bind pooling_window_engine_unit pwe_checker u_pwe_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall,
  .pooled_value, .valid_cells, .out_of_range
);
